>>> rtl/core/xcfp_pkg.sv
`timescale 1ns / 1ps

package xcfp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 17;
  localparam int unsigned IndexW = 16;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 17;

  localparam logic [ByteW-1:0]  HeaderFirstReset  = 8'hAA;
  localparam logic [ByteW-1:0]  HeaderSecondReset = 8'h70;
  localparam logic [CountW-1:0] MaxLengthReset    = 17'd1024;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegHeaderFirst  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeaderSecond = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxLength    = 2'd2;

  typedef enum logic [KindW-1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BADSUM  = 2'd2,
    KIND_BADLEN  = 2'd3
  } xcfp_kind_e;

  typedef struct packed {
    logic [ByteW-1:0]  header_first;
    logic [ByteW-1:0]  header_second;
    logic [CountW-1:0] max_length;
  } xcfp_cfg_t;

  typedef struct packed {
    xcfp_kind_e        kind;
    logic [ByteW-1:0]  command;
    logic [IndexW-1:0] index;
    logic [ByteW-1:0]  data;
    logic              frame_end;
  } xcfp_result_t;

endpackage

>>> rtl/core/xcfp_parser.sv
`timescale 1ns / 1ps

module xcfp_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             byte_i,
  input  xcfp_pkg::xcfp_cfg_t    cfg_i,
  output logic                   has_result_o,
  output xcfp_pkg::xcfp_result_t result_o
);
  import xcfp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_FIRST   = 3'd1,
    PH_SECOND  = 3'd2,
    PH_COMMAND = 3'd3,
    PH_LENLOW  = 3'd4,
    PH_BODY    = 3'd5
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  xor_q, xor_d;
  logic [ByteW-1:0]  command_q, command_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] position_q, position_d;
  logic [CountW-1:0] new_count;

  // Length is high byte, low byte, plus one; it fits in 17 bits.
  assign new_count = {1'b0, byte_i, count_q[ByteW-1:0]} + CountW'(1);

  always_comb begin
    phase_d    = phase_q;
    xor_d      = xor_q;
    command_d  = command_q;
    count_d    = count_q;
    position_d = position_q;
    has_result_o       = 1'b0;
    result_o.kind      = KIND_PAYLOAD;
    result_o.command   = command_q;
    result_o.index     = '0;
    result_o.data      = '0;
    result_o.frame_end = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (byte_i == cfg_i.header_first) begin
          phase_d = PH_FIRST;
        end
      end
      PH_FIRST: begin
        phase_d = (byte_i == cfg_i.header_second) ? PH_SECOND : PH_IDLE;
      end
      PH_SECOND: begin
        command_d = byte_i;
        xor_d     = byte_i ^ cfg_i.header_first ^ cfg_i.header_second;
        phase_d   = PH_COMMAND;
      end
      PH_COMMAND: begin
        count_d = {{(CountW-ByteW){1'b0}}, byte_i};
        xor_d   = xor_q ^ byte_i;
        phase_d = PH_LENLOW;
      end
      PH_LENLOW: begin
        count_d    = new_count;
        xor_d      = xor_q ^ byte_i;
        position_d = '0;
        if (new_count > cfg_i.max_length) begin
          phase_d            = PH_IDLE;
          has_result_o       = 1'b1;
          result_o.kind      = KIND_BADLEN;
          result_o.frame_end = 1'b1;
        end else begin
          phase_d = PH_BODY;
        end
      end
      PH_BODY: begin
        has_result_o = 1'b1;
        if (position_q < count_q) begin
          xor_d          = xor_q ^ byte_i;
          position_d     = position_q + CountW'(1);
          result_o.index = position_q[IndexW-1:0];
          result_o.data  = byte_i;
        end else begin
          phase_d            = PH_IDLE;
          result_o.kind      = (xor_q == byte_i) ? KIND_GOOD : KIND_BADSUM;
          result_o.frame_end = 1'b1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      xor_q      <= '0;
      command_q  <= '0;
      count_q    <= '0;
      position_q <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      xor_q      <= xor_d;
      command_q  <= command_d;
      count_q    <= count_d;
      position_q <= position_d;
    end
  end

endmodule

>>> rtl/core/xor_checked_frame_parser_core.sv
`timescale 1ns / 1ps

// Frame parser with XOR checksum.
// Received bytes enter on the in_* channel, one transfer per byte. The parser
// looks for the two header bytes, then takes a command byte and a 16-bit
// length (low byte first); the payload count is that length plus one. Each
// payload byte leaves on the out_* channel with its index, and the byte after
// the payload closes the frame with frame good or checksum error. A count
// above max_length closes the frame with a length error. Header, command and
// length bytes give no output transfer, but for that length error.
// A byte taken goes into the input register, and the parser writes its result
// into the output register when it steps. One byte per cycle is sustained while
// the receiver takes results; the input register and the output register each
// hold one item, so a stalled receiver stops the input only once both are full.
// Reset returns the parser to idle, empties both registers and loads the
// header and max_length registers with their defaults. Configuration writes
// take effect at the next edge and are meant to be made while idle.
module xor_checked_frame_parser_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [xcfp_pkg::ByteW-1:0]          rx_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [xcfp_pkg::KindW-1:0]          result_kind_o,
  output logic [xcfp_pkg::ByteW-1:0]          command_o,
  output logic [xcfp_pkg::IndexW-1:0]         payload_index_o,
  output logic [xcfp_pkg::ByteW-1:0]          payload_byte_o,
  output logic                                frame_end_o,
  input  logic                                cfg_we_i,
  input  logic [xcfp_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [xcfp_pkg::CfgDataW-1:0]       cfg_wdata_i
);
  import xcfp_pkg::*;

  xcfp_cfg_t        cfg_q;
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  xcfp_result_t     out_q;
  logic             has_result;
  xcfp_result_t     result;
  logic             out_free;
  logic             step;

  assign out_free   = !out_valid_q || out_ready_i;
  // A byte with no result may move on even while the output is full.
  assign step       = in_valid_q && (out_free || !has_result);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first  <= HeaderFirstReset;
      cfg_q.header_second <= HeaderSecondReset;
      cfg_q.max_length    <= MaxLengthReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegHeaderFirst:  cfg_q.header_first  <= cfg_wdata_i[ByteW-1:0];
        RegHeaderSecond: cfg_q.header_second <= cfg_wdata_i[ByteW-1:0];
        RegMaxLength:    cfg_q.max_length    <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  xcfp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .byte_i       (in_byte_q),
    .cfg_i        (cfg_q),
    .has_result_o (has_result),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && step && has_result) begin
      out_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = out_q.kind;
  assign command_o       = out_q.command;
  assign payload_index_o = out_q.index;
  assign payload_byte_o  = out_q.data;
  assign frame_end_o     = out_q.frame_end;

endmodule
